>>> hdl/cjk_bigram_token_splitter_defines.svh
// assertion macros for the cjk bigram token splitter
// the checks use the clock clk and the active-low reset rst_n of the including module
`ifndef CJK_BIGRAM_TOKEN_SPLITTER_DEFINES_SVH
`define CJK_BIGRAM_TOKEN_SPLITTER_DEFINES_SVH

`ifndef SYNTHESIS
`define CBTS_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CBTS_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CBTS_CHECK(label, ante, cons, msg)
`define CBTS_CHECK_NEXT(label, ante, cons, msg)
`endif

`endif

>>> hdl/cbts_pkg.sv
`default_nettype none

package cbts_pkg;

    localparam int TOKEN_POS_BITS_DEFAULT = 12;
    localparam int TEXT_POS_BITS_DEFAULT  = 24;

    // result queue between front and back
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        KIND_PLAIN   = 2'd0,
        KIND_BIGRAM  = 2'd1,
        KIND_UNIGRAM = 2'd2
    } seg_kind_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // flat width of one queue record: pair flag, two segments, text offsets, flag
    function automatic int rec_width(input int tp, input int xp);
        return 2 + 2 * (2 + 2 * tp + 1) + 2 * xp;
    endfunction

    function automatic logic is_cjk(input logic [20:0] c);
        return (c >= 21'h0AC00 && c <= 21'h0D7A3) || (c >= 21'h01100 && c <= 21'h011FF)
            || (c >= 21'h03130 && c <= 21'h0318F) || (c >= 21'h0A960 && c <= 21'h0A97F)
            || (c >= 21'h0D7B0 && c <= 21'h0D7FF) || (c >= 21'h04E00 && c <= 21'h09FFF)
            || (c >= 21'h03400 && c <= 21'h04DBF) || (c >= 21'h0F900 && c <= 21'h0FAFF)
            || (c >= 21'h20000 && c <= 21'h2FA1F) || (c >= 21'h03040 && c <= 21'h0309F)
            || (c >= 21'h030A0 && c <= 21'h030FF) || (c >= 21'h031F0 && c <= 21'h031FF);
    endfunction

endpackage

`default_nettype wire

>>> hdl/cbts_front.sv
`default_nettype none

module cbts_front
    import cbts_pkg::*;
#(
    parameter int TOKEN_POS_BITS = TOKEN_POS_BITS_DEFAULT,
    parameter int TEXT_POS_BITS  = TEXT_POS_BITS_DEFAULT,
    parameter int REC_W          = rec_width(TOKEN_POS_BITS, TEXT_POS_BITS)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     byte_valid,
    output logic                     byte_ready,
    input  logic [7:0]               data_byte,
    input  logic                     last_of_token,
    input  logic [TEXT_POS_BITS-1:0] token_start,
    input  logic [TEXT_POS_BITS-1:0] token_end,
    input  logic                     token_flags,
    input  qstat_t                   qstat,
    output logic                     push,
    output logic [REC_W-1:0]         rec
);

    typedef logic [TOKEN_POS_BITS-1:0] pos_t;

    typedef struct packed {
        seg_kind_t kind;
        pos_t      s;
        pos_t      e;
        logic      whole;
    } seg_t;

    typedef struct packed {
        logic                     two;
        seg_t [1:0]               seg;
        logic [TEXT_POS_BITS-1:0] tstart;
        logic [TEXT_POS_BITS-1:0] tend;
        logic                     flags;
    } rec_t;

    typedef enum logic [2:0] {
        RUN_NONE  = 3'b001,
        RUN_PLAIN = 3'b010,
        RUN_CJK   = 3'b100
    } run_t;

    function automatic seg_t mk(input seg_kind_t k, input pos_t s, input pos_t e,
                                input logic w);
        seg_t r;
        r.kind  = k;
        r.s     = s;
        r.e     = e;
        r.whole = w;
        return r;
    endfunction

    pos_t        pos_reg, pos_next;
    logic [20:0] partial_reg, partial_next;
    logic [1:0]  expect_reg, expect_next;
    pos_t        cstart_reg, cstart_next;
    run_t        run_reg, run_next;
    pos_t        run_start_reg, run_start_next;
    pos_t        wfirst_reg, wfirst_next;
    pos_t        wmid_reg, wmid_next;
    logic        lone_reg, lone_next;
    logic        has_cjk_reg, has_cjk_next;

    logic        fire;
    pos_t        pos_after;
    logic [20:0] cp;
    logic [20:0] part;
    logic        done;
    logic        char_cjk;
    logic        have0, have1;
    seg_t        seg0, seg1;
    rec_t        rec_w;

    assign byte_ready = !qstat.full;
    assign fire       = byte_valid && byte_ready;
    assign pos_after  = (&pos_reg) ? pos_reg : pos_reg + 1'b1;
    assign part       = {partial_reg[14:0], data_byte[5:0]};

    always_comb
    begin
        pos_next       = pos_after;
        partial_next   = partial_reg;
        expect_next    = expect_reg;
        cstart_next    = cstart_reg;
        run_next       = run_reg;
        run_start_next = run_start_reg;
        wfirst_next    = wfirst_reg;
        wmid_next      = wmid_reg;
        lone_next      = lone_reg;
        has_cjk_next   = has_cjk_reg;
        done           = 1'b0;
        cp             = '0;
        have0          = 1'b0;
        have1          = 1'b0;
        seg0           = '0;
        seg1           = '0;

        // loose utf-8 decode
        if (expect_reg == 2'd0)
        begin
            cstart_next = pos_reg;
            if (!data_byte[7])
            begin
                cp   = {13'd0, data_byte};
                done = 1'b1;
            end
            else if ((data_byte & 8'hE0) == 8'hC0)
            begin
                partial_next = {16'd0, data_byte[4:0]};
                expect_next  = 2'd1;
            end
            else if ((data_byte & 8'hF0) == 8'hE0)
            begin
                partial_next = {17'd0, data_byte[3:0]};
                expect_next  = 2'd2;
            end
            else if ((data_byte & 8'hF8) == 8'hF0)
            begin
                partial_next = {18'd0, data_byte[2:0]};
                expect_next  = 2'd3;
            end
            else
            begin
                cp   = {13'd0, data_byte};
                done = 1'b1;
            end
        end
        else
        begin
            partial_next = part;
            expect_next  = expect_reg - 2'd1;
            if (expect_reg == 2'd1)
            begin
                cp   = part;
                done = 1'b1;
            end
        end

        char_cjk = done && is_cjk(cp);

        // one character completed, or a cut-off sequence at token end
        if (done || last_of_token)
        begin
            if (!char_cjk)
            begin
                if (run_reg == RUN_CJK && lone_reg)
                begin
                    seg0  = mk(KIND_UNIGRAM, run_start_reg, wmid_reg, 1'b0);
                    have0 = 1'b1;
                end
                if (run_reg != RUN_PLAIN)
                begin
                    run_next       = RUN_PLAIN;
                    run_start_next = cstart_next;
                end
            end
            else
            begin
                has_cjk_next = 1'b1;
                if (run_reg == RUN_CJK)
                begin
                    seg0        = mk(KIND_BIGRAM, wfirst_reg, pos_after, 1'b0);
                    have0       = 1'b1;
                    wfirst_next = wmid_reg;
                    wmid_next   = pos_after;
                    lone_next   = 1'b0;
                end
                else
                begin
                    if (run_reg == RUN_PLAIN)
                    begin
                        seg0  = mk(KIND_PLAIN, run_start_reg, cstart_next, 1'b0);
                        have0 = 1'b1;
                    end
                    run_next       = RUN_CJK;
                    run_start_next = cstart_next;
                    wfirst_next    = cstart_next;
                    wmid_next      = pos_after;
                    lone_next      = 1'b1;
                end
            end
        end

        // close the open run at token end
        if (last_of_token)
        begin
            if (run_next == RUN_PLAIN)
            begin
                if (have0)
                begin
                    seg1  = mk(KIND_PLAIN, run_start_next, pos_after, !has_cjk_next);
                    have1 = 1'b1;
                end
                else
                begin
                    seg0  = mk(KIND_PLAIN, run_start_next, pos_after, !has_cjk_next);
                    have0 = 1'b1;
                end
            end
            else if (run_next == RUN_CJK && lone_next)
            begin
                if (have0)
                begin
                    seg1  = mk(KIND_UNIGRAM, run_start_next, wmid_next, 1'b0);
                    have1 = 1'b1;
                end
                else
                begin
                    seg0  = mk(KIND_UNIGRAM, run_start_next, wmid_next, 1'b0);
                    have0 = 1'b1;
                end
            end
            pos_next       = '0;
            partial_next   = '0;
            expect_next    = '0;
            cstart_next    = '0;
            run_next       = RUN_NONE;
            run_start_next = '0;
            wfirst_next    = '0;
            wmid_next      = '0;
            lone_next      = 1'b0;
            has_cjk_next   = 1'b0;
        end
    end

    always_comb
    begin
        rec_w.two    = have1;
        rec_w.seg[0] = seg0;
        rec_w.seg[1] = seg1;
        rec_w.tstart = token_start;
        rec_w.tend   = token_end;
        rec_w.flags  = token_flags;
    end

    assign push = fire && have0;
    assign rec  = rec_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            partial_reg   <= '0;
            expect_reg    <= '0;
            cstart_reg    <= '0;
            run_reg       <= RUN_NONE;
            run_start_reg <= '0;
            wfirst_reg    <= '0;
            wmid_reg      <= '0;
            lone_reg      <= 1'b0;
            has_cjk_reg   <= 1'b0;
        end
        else if (fire)
        begin
            pos_reg       <= pos_next;
            partial_reg   <= partial_next;
            expect_reg    <= expect_next;
            cstart_reg    <= cstart_next;
            run_reg       <= run_next;
            run_start_reg <= run_start_next;
            wfirst_reg    <= wfirst_next;
            wmid_reg      <= wmid_next;
            lone_reg      <= lone_next;
            has_cjk_reg   <= has_cjk_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/cbts_queue.sv
`default_nettype none

module cbts_queue
    import cbts_pkg::*;
#(
    parameter int WIDTH = rec_width(TOKEN_POS_BITS_DEFAULT, TEXT_POS_BITS_DEFAULT)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output qstat_t           qstat
);

    logic [WIDTH-1:0]        mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_PTR_BITS:0]   count_reg, count_next;

    assign rdata       = mem[rd_ptr_reg];
    assign qstat.full  = (count_reg == QUEUE_DEPTH[QUEUE_PTR_BITS:0]);
    assign qstat.empty = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/cbts_back.sv
`default_nettype none

module cbts_back
    import cbts_pkg::*;
#(
    parameter int TOKEN_POS_BITS = TOKEN_POS_BITS_DEFAULT,
    parameter int TEXT_POS_BITS  = TEXT_POS_BITS_DEFAULT,
    parameter int REC_W          = rec_width(TOKEN_POS_BITS, TEXT_POS_BITS)
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [REC_W-1:0]          rec,
    input  qstat_t                    qstat,
    output logic                      pop,
    output logic                      seg_valid,
    input  logic                      seg_ready,
    output logic [1:0]                segment_kind,
    output logic [TOKEN_POS_BITS-1:0] segment_offset,
    output logic [TOKEN_POS_BITS-1:0] segment_length,
    output logic [TEXT_POS_BITS-1:0]  text_begin,
    output logic [TEXT_POS_BITS-1:0]  text_finish,
    output logic                      passed_flags,
    output logic                      last_result
);

    typedef logic [TOKEN_POS_BITS-1:0] pos_t;
    typedef logic [TEXT_POS_BITS-1:0]  txt_t;

    typedef struct packed {
        seg_kind_t kind;
        pos_t      s;
        pos_t      e;
        logic      whole;
    } seg_t;

    typedef struct packed {
        logic       two;
        seg_t [1:0] seg;
        txt_t       tstart;
        txt_t       tend;
        logic       flags;
    } rec_t;

    function automatic txt_t clamp(input txt_t start, input txt_t stop, input pos_t pos);
        logic [TEXT_POS_BITS:0] v;
        v = {1'b0, start} + {{(TEXT_POS_BITS + 1 - TOKEN_POS_BITS){1'b0}}, pos};
        return (v > {1'b0, stop}) ? stop : v[TEXT_POS_BITS-1:0];
    endfunction

    rec_t head;
    seg_t cur;
    logic sel_reg, sel_next;
    logic load, take, final_one;

    logic      valid_reg, valid_next;
    seg_kind_t kind_reg;
    pos_t      offset_reg, length_reg;
    txt_t      begin_reg, finish_reg;
    logic      flags_reg, last_reg;

    assign head      = rec_t'(rec);
    assign cur       = head.seg[sel_reg];
    assign final_one = !head.two || sel_reg;
    assign load      = !valid_reg || seg_ready;
    assign take      = load && !qstat.empty;
    assign pop       = take && final_one;

    always_comb
    begin
        sel_next   = sel_reg;
        valid_next = valid_reg;
        if (take)
        begin
            sel_next   = !final_one;
            valid_next = 1'b1;
        end
        else if (seg_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sel_reg   <= sel_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg   <= cur.kind;
            offset_reg <= cur.s;
            length_reg <= cur.e - cur.s;
            begin_reg  <= cur.whole ? head.tstart : clamp(head.tstart, head.tend, cur.s);
            finish_reg <= cur.whole ? head.tend : clamp(head.tstart, head.tend, cur.e);
            flags_reg  <= head.flags;
            last_reg   <= final_one;
        end
    end

    assign seg_valid      = valid_reg;
    assign segment_kind   = kind_reg;
    assign segment_offset = offset_reg;
    assign segment_length = length_reg;
    assign text_begin     = begin_reg;
    assign text_finish    = finish_reg;
    assign passed_flags   = flags_reg;
    assign last_result    = last_reg;

endmodule

`default_nettype wire

>>> hdl/cjk_bigram_token_splitter.sv
// channel   | handshake              | payload
// ----------+------------------------+------------------------------------------------
// byte in   | byte_valid, byte_ready | data_byte, last_of_token, token_start,
//           |                        | token_end, token_flags
// segment   | seg_valid, seg_ready   | segment_kind, segment_offset, segment_length,
//           |                        | text_begin, text_finish, passed_flags, last_result
//
// one byte transfer per cycle while the result queue is not full; a byte that closes
// two segments hands them to the output register one after the other
// a segment closed by a byte transfer passes through the queue write, then the output
// register, and can wait in the queue while the output register is held
// output stalls fill the four-entry result queue; byte_ready drops only when it is full
// rst_n clears all token state, the queue and the output valid flag at once
`default_nettype none

`include "cjk_bigram_token_splitter_defines.svh"

module cjk_bigram_token_splitter
    import cbts_pkg::*;
#(
    parameter int TOKEN_POS_BITS = TOKEN_POS_BITS_DEFAULT,
    parameter int TEXT_POS_BITS  = TEXT_POS_BITS_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // byte channel
    input  logic                      byte_valid,
    output logic                      byte_ready,
    input  logic [7:0]                data_byte,
    input  logic                      last_of_token,
    input  logic [TEXT_POS_BITS-1:0]  token_start,
    input  logic [TEXT_POS_BITS-1:0]  token_end,
    input  logic                      token_flags,
    // segment channel
    output logic                      seg_valid,
    input  logic                      seg_ready,
    output logic [1:0]                segment_kind,
    output logic [TOKEN_POS_BITS-1:0] segment_offset,
    output logic [TOKEN_POS_BITS-1:0] segment_length,
    output logic [TEXT_POS_BITS-1:0]  text_begin,
    output logic [TEXT_POS_BITS-1:0]  text_finish,
    output logic                      passed_flags,
    output logic                      last_result
);

    // one queue record carries every segment closed by a single byte
    localparam int REC_W = rec_width(TOKEN_POS_BITS, TEXT_POS_BITS);

    qstat_t           qstat;
    logic             push;
    logic             pop;
    logic [REC_W-1:0] wrec;
    logic [REC_W-1:0] rrec;

    // front: utf-8 decode, cjk classing and run tracking, one byte per cycle while the queue is not full
    cbts_front #(
        .TOKEN_POS_BITS (TOKEN_POS_BITS),
        .TEXT_POS_BITS  (TEXT_POS_BITS),
        .REC_W          (REC_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_ready    (byte_ready),
        .data_byte     (data_byte),
        .last_of_token (last_of_token),
        .token_start   (token_start),
        .token_end     (token_end),
        .token_flags   (token_flags),
        .qstat         (qstat),
        .push          (push),
        .rec           (wrec)
    );

    // short queue so the front keeps taking bytes while the output stalls
    cbts_queue #(
        .WIDTH (REC_W)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (wrec),
        .pop   (pop),
        .rdata (rrec),
        .qstat (qstat)
    );

    // back: splits records into single segments, works out clamped text offsets
    cbts_back #(
        .TOKEN_POS_BITS (TOKEN_POS_BITS),
        .TEXT_POS_BITS  (TEXT_POS_BITS),
        .REC_W          (REC_W)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .rec            (rrec),
        .qstat          (qstat),
        .pop            (pop),
        .seg_valid      (seg_valid),
        .seg_ready      (seg_ready),
        .segment_kind   (segment_kind),
        .segment_offset (segment_offset),
        .segment_length (segment_length),
        .text_begin     (text_begin),
        .text_finish    (text_finish),
        .passed_flags   (passed_flags),
        .last_result    (last_result)
    );

    // queue must never overflow or underflow
    `CBTS_CHECK(a_no_push_full, push, !qstat.full, "result queue written while full")
    `CBTS_CHECK(a_no_pop_empty, pop, !qstat.empty, "result queue read while empty")
    // nothing reaches the output without passing through the queue
    `CBTS_CHECK_NEXT(a_no_phantom, qstat.empty && !seg_valid, !seg_valid, "segment from empty queue")
    // clamped cjk segments keep their text offsets in order
    `CBTS_CHECK(a_text_order, seg_valid && (segment_kind != KIND_PLAIN), text_begin <= text_finish, "cjk segment text offsets reversed")

endmodule

`default_nettype wire
